[hdl/slq_pkg.sv]
package slq_pkg;

  // List depth and the widths that follow from it
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths of the request and response
  localparam int FUNC_W   = 3;
  localparam int DATA_W   = 32;
  localparam int STAT_W   = 2;
  localparam int POS_W    = 4;
  localparam int COUNT_W  = 5;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT  = 3'd0,
    FUNC_POP_MIN = 3'd1,
    FUNC_POP_MAX = 3'd2,
    FUNC_CLEAR   = 3'd3,
    FUNC_SEARCH  = 3'd4
  } func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;  // capture the incoming request
    logic exec;  // apply the held request and load the response register
  } cmd_t;

endpackage

[hdl/slq_req_if.sv]
interface slq_req_if
  import slq_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  data_t             value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

[hdl/slq_rsp_if.sv]
interface slq_rsp_if
  import slq_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic               found;
  logic [POS_W-1:0]   position;
  logic [COUNT_W-1:0] count;
  data_t              smallest;
  data_t              largest;

  modport source (output valid, output status, output found, output position,
                  output count, output smallest, output largest, input ready);
  modport sink   (input valid, input status, input found, input position,
                  input count, input smallest, input largest, output ready);
endinterface

[hdl/slq_ctrl.sv]
module slq_ctrl
  import slq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // response slot is free when empty or being drained this cycle
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_EXEC: begin
        cmd.exec = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_load_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_EXEC)
    else $error("request captured but controller not executing");

  a_exec_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> out_valid_r)
    else $error("executed request produced no response");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> (!out_valid_r || out_ready))
    else $error("response register overwritten while still pending");

endmodule

[hdl/slq_dp.sv]
module slq_dp
  import slq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  input  logic [FUNC_W-1:0]  func,
  input  data_t              value,
  output logic [STAT_W-1:0]  rsp_status,
  output logic               rsp_found,
  output logic [POS_W-1:0]   rsp_position,
  output logic [COUNT_W-1:0] rsp_count,
  output data_t              rsp_smallest,
  output data_t              rsp_largest
);

  // held request
  logic [FUNC_W-1:0] func_r;
  data_t             value_r;

  // list cells and fill level
  data_t             entry_r   [CAPACITY];
  data_t             entry_nxt [CAPACITY];
  logic [CNT_W-1:0]  count_r, count_nxt;

  // response register
  logic [STAT_W-1:0]  status_r, status_nxt;
  logic               found_r, found_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [COUNT_W-1:0] cnt_out_r;
  data_t              small_r, small_nxt;
  data_t              large_r, large_nxt;

  logic [CAPACITY-1:0] lt;   // cell valid and below the request value
  logic [CAPACITY-1:0] eq;   // cell valid and equal to it
  logic [IDX_W-1:0]    hit_idx;
  logic [IDX_W-1:0]    last_idx;
  logic                full, empty;

  assign full  = (count_r == CNT_W'(CAPACITY));
  assign empty = (count_r == '0);

  // per-cell compares
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt[i] = (CNT_W'(i) < count_r) && (entry_r[i] < value_r);
      eq[i] = (CNT_W'(i) < count_r) && (entry_r[i] == value_r);
    end
  end

  // lowest matching cell
  always_comb begin
    hit_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (eq[i]) hit_idx = IDX_W'(i);
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) entry_nxt[i] = entry_r[i];
    count_nxt  = count_r;
    status_nxt = ST_OK;
    found_nxt  = 1'b0;
    pos_nxt    = '0;
    case (func_r)
      FUNC_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          // cells below the slot hold, the slot takes the value, the rest move up
          if (!lt[0]) entry_nxt[0] = value_r;
          for (int i = 1; i < CAPACITY; i++) begin
            if (!lt[i]) begin
              entry_nxt[i] = lt[i-1] ? value_r : entry_r[i-1];
            end
          end
          count_nxt = count_r + CNT_W'(1);
        end
      end
      FUNC_POP_MIN: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          for (int i = 0; i < CAPACITY - 1; i++) entry_nxt[i] = entry_r[i+1];
          count_nxt = count_r - CNT_W'(1);
        end
      end
      FUNC_POP_MAX: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      FUNC_CLEAR: begin
        count_nxt = '0;
      end
      FUNC_SEARCH: begin
        found_nxt = |eq;
        pos_nxt   = (|eq) ? POS_W'(hit_idx) : '0;
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // summary of the list after the operation
  assign last_idx = IDX_W'(count_nxt - CNT_W'(1));

  always_comb begin
    if (count_nxt == '0) begin
      small_nxt = '0;
      large_nxt = '0;
    end else begin
      small_nxt = entry_nxt[0];
      large_nxt = entry_nxt[last_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= func;
      value_r <= value;
    end
    if (cmd.exec) begin
      for (int i = 0; i < CAPACITY; i++) entry_r[i] <= entry_nxt[i];
      status_r  <= status_nxt;
      found_r   <= found_nxt;
      pos_r     <= pos_nxt;
      cnt_out_r <= COUNT_W'(count_nxt);
      small_r   <= small_nxt;
      large_r   <= large_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  assign rsp_status   = status_r;
  assign rsp_found    = found_r;
  assign rsp_position = pos_r;
  assign rsp_count    = cnt_out_r;
  assign rsp_smallest = small_r;
  assign rsp_largest  = large_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("fill level beyond capacity");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && func_r == FUNC_CLEAR) |=> count_r == '0)
    else $error("clear left entries behind");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && func_r == FUNC_INSERT && full) |=> full)
    else $error("insert into full list changed the fill level");

endmodule

[hdl/sorted_list_queue.sv]
// Sorted list queue: holds up to 16 signed 32-bit values in ascending order.
// Each request carries func and value: insert (placed before equal values),
// remove smallest, remove largest, clear, or search. Every request gives
// exactly one response with status (ok, full - insert dropped, empty -
// nothing removed), found and position for a search, and the count,
// smallest and largest entries after the operation (zero when empty).
// Timing: a request is captured in idle, then in execute all cells compare
// against the value in parallel and shift in a single step; the response
// register then holds the result while the next request is captured. A
// request waits in execute only while a previous response is still untaken,
// and no new request is accepted until the held one has been executed.
// Unknown func codes change nothing and report the current list. Entries
// above the fill level are never reported, so no clearing pass is needed
// after reset.
module sorted_list_queue
  import slq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  slq_req_if.sink   in_req,
  slq_rsp_if.source out_rsp
);

  cmd_t cmd;

  // handshake control
  slq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .cmd       (cmd)
  );

  // list cells, compares and response register
  slq_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .func         (in_req.func),
    .value        (in_req.value),
    .rsp_status   (out_rsp.status),
    .rsp_found    (out_rsp.found),
    .rsp_position (out_rsp.position),
    .rsp_count    (out_rsp.count),
    .rsp_smallest (out_rsp.smallest),
    .rsp_largest  (out_rsp.largest)
  );

endmodule
